>>> hdl/rrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_pkg
// Types and constants shared by the realtime rate meter modules.
// ----------------------------------------------------------------------------
package rrm_pkg;

    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 16;
    localparam int RATE_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int QUO_W    = TIME_W + FRAC_W;
    localparam int STEP_W   = 7;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000000);
    localparam logic [STEP_W-1:0]   STEPS_FULL   = STEP_W'(QUO_W);
    localparam logic [STEP_W-1:0]   STEPS_TIME   = STEP_W'(TIME_W);

    typedef enum logic [1:0] {
        RRM_INCOMPLETE  = 2'd0,
        RRM_INITIALIZED = 2'd1,
        RRM_COMPUTED    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DIV_RATE  = 2'd0,
        DIV_COUNT = 2'd1,
        DIV_ADV   = 2'd2
    } div_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL_SUB,
        ST_EVAL_WALL,
        ST_DECIDE,
        ST_RATE_DIV,
        ST_COUNT_DIV,
        ST_ADV_MUL,
        ST_ADV_DIV,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic [TIME_W-1:0] sim_time;
        logic              sim_time_invalid;
        logic [TIME_W-1:0] wall_time;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] whole_periods;
        logic [RATE_W-1:0]  rate;
    } out_item_t;

    typedef struct packed {
        logic    load;
        logic    eval_sub;
        logic    eval_wall;
        logic    mark_origin;
        logic    div_start;
        div_op_t div_op;
        logic    cap_rate;
        logic    cap_count;
        logic    mul_start;
        logic    update;
        logic    emit;
        status_t result;
    } dp_cmd_t;

    typedef struct packed {
        logic invalid;
        logic started;
        logic sim_lt;
        logic sim_eq;
        logic short_wait;
        logic div_done;
        logic mul_done;
        logic div_busy;
        logic mul_busy;
    } dp_status_t;

endpackage
`default_nettype wire

>>> hdl/realtime_rate_meter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// realtime_rate_meter_core
// Measures simulated time against wall time and reports rate and periods.
//
//   channel   dir   handshake                 payload
//   s_        in    s_valid / s_ready         rrm_pkg::in_item_t
//   m_        out   m_valid / m_ready         rrm_pkg::out_item_t
//   cfg_      in    cfg_valid / cfg_ready     period length, 32 bits
//
// one item at a time; an incomplete or origin item skips the divider
// a computed item runs a 64-step and a 48-step division, a 48-step
// multiply and a 48-step division; the three divisions share one divider
// a finished item waits in the output register while the next item is taken
// reset clears the marks and loads the period length with 1000000
// ----------------------------------------------------------------------------
module realtime_rate_meter_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire rrm_pkg::in_item_t            s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output rrm_pkg::out_item_t                m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rrm_pkg::PERIOD_W-1:0] cfg_data
);

    rrm_pkg::dp_cmd_t    cmd;
    rrm_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    rrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (cmd)
    );

    rrm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .in_item  (s_data),
        .cmd      (cmd),
        .status   (dp_status),
        .out_item (m_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while another is in progress");

    a_zero_unless_computed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != rrm_pkg::RRM_COMPUTED) |->
        (m_data.rate == '0) && (m_data.whole_periods == '0))
        else $error("rate or count nonzero on non-computed item");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dp_status.div_busy && dp_status.mul_busy))
        else $error("divider and multiplier busy together");

endmodule
`default_nettype wire

>>> hdl/rrm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_div
// Restoring divider, one quotient bit per cycle, with a preset remainder.
// ----------------------------------------------------------------------------
module rrm_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [rrm_pkg::TIME_W-1:0]    rem_init,
    input  wire logic [rrm_pkg::QUO_W-1:0]     dividend,
    input  wire logic [rrm_pkg::TIME_W-1:0]    divisor,
    input  wire logic [rrm_pkg::STEP_W-1:0]    steps,
    output logic                               busy,
    output logic                               done,
    output logic [rrm_pkg::QUO_W-1:0]          quotient,
    output logic [rrm_pkg::TIME_W-1:0]         remainder
);

    logic [rrm_pkg::TIME_W-1:0] rem_reg, rem_next;
    logic [rrm_pkg::QUO_W-1:0]  num_reg;
    logic [rrm_pkg::QUO_W-1:0]  quo_reg;
    logic [rrm_pkg::TIME_W-1:0] dvs_reg;
    logic [rrm_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [rrm_pkg::TIME_W:0]   shifted;
    logic [rrm_pkg::TIME_W:0]   diff;
    logic                       ge;

    always_comb begin
        shifted  = {rem_reg, num_reg[rrm_pkg::QUO_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[rrm_pkg::TIME_W-1:0] : shifted[rrm_pkg::TIME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rrm_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            num_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[rrm_pkg::QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[rrm_pkg::QUO_W-2:0], ge};
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

>>> hdl/rrm_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_mul
// Shift-add multiplier, one multiplier bit per cycle, full-width product.
// ----------------------------------------------------------------------------
module rrm_mul (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rrm_pkg::TIME_W-1:0] mcand,
    input  wire logic [rrm_pkg::TIME_W-1:0] mplier,
    output logic                            busy,
    output logic                            done,
    output logic [rrm_pkg::TIME_W-1:0]      prod_hi,
    output logic [rrm_pkg::TIME_W-1:0]      prod_lo
);

    logic [rrm_pkg::TIME_W-1:0] acc_reg;
    logic [rrm_pkg::TIME_W-1:0] lo_reg;
    logic [rrm_pkg::TIME_W-1:0] mcand_reg;
    logic [rrm_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [rrm_pkg::TIME_W:0]   sum;

    always_comb begin
        sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= rrm_pkg::STEPS_TIME;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rrm_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg   <= '0;
            lo_reg    <= mplier;
            mcand_reg <= mcand;
        end else if (busy_reg) begin
            acc_reg <= sum[rrm_pkg::TIME_W:1];
            lo_reg  <= {sum[0], lo_reg[rrm_pkg::TIME_W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign prod_hi = acc_reg;
    assign prod_lo = lo_reg;

endmodule
`default_nettype wire

>>> hdl/rrm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_datapath
// Marks, deltas, period register, shared divider, multiplier, result item.
// ----------------------------------------------------------------------------
module rrm_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [rrm_pkg::PERIOD_W-1:0] cfg_data,
    input  wire rrm_pkg::in_item_t            in_item,
    input  wire rrm_pkg::dp_cmd_t             cmd,
    output rrm_pkg::dp_status_t               status,
    output rrm_pkg::out_item_t                out_item
);

    localparam int TW = rrm_pkg::TIME_W;

    rrm_pkg::in_item_t           item_reg;
    rrm_pkg::out_item_t          out_reg;
    logic [TW-1:0]               sd_reg;
    logic                        sim_lt_reg;
    logic                        sim_eq_reg;
    logic [TW-1:0]               elapsed_reg;
    logic [TW-1:0]               wd_reg;
    logic [TW-1:0]               adv_reg;
    logic                        started_reg;
    logic [TW-1:0]               last_sim_reg;
    logic [TW-1:0]               last_wall_reg;
    logic [TW-1:0]               origin_reg;
    logic [rrm_pkg::PERIOD_W-1:0] period_reg;
    logic [rrm_pkg::RATE_W-1:0]  rate_reg;
    logic [rrm_pkg::COUNT_W-1:0] count_reg;

    logic [rrm_pkg::PERIOD_W-1:0] period_eff;
    logic [TW:0]                  sim_diff;
    logic [TW-1:0]                adv;
    logic [TW-1:0]                div_rem0;
    logic [rrm_pkg::QUO_W-1:0]    div_num;
    logic [TW-1:0]                div_dvs;
    logic [rrm_pkg::STEP_W-1:0]   div_steps;
    logic                         div_busy;
    logic                         div_done;
    logic [rrm_pkg::QUO_W-1:0]    div_quo;
    logic [TW-1:0]                div_rem;
    logic                         mul_busy;
    logic                         mul_done;
    logic [TW-1:0]                mul_hi;
    logic [TW-1:0]                mul_lo;

    always_comb begin
        period_eff = (period_reg == '0) ? rrm_pkg::PERIOD_W'(1) : period_reg;
        sim_diff   = {1'b0, item_reg.sim_time} - {1'b0, last_sim_reg};
        adv        = wd_reg - div_rem;
        div_rem0   = '0;
        div_num    = {sd_reg, {rrm_pkg::FRAC_W{1'b0}}};
        div_dvs    = wd_reg;
        div_steps  = rrm_pkg::STEPS_FULL;
        case (cmd.div_op)
            rrm_pkg::DIV_RATE: begin
                div_num   = {sd_reg, {rrm_pkg::FRAC_W{1'b0}}};
                div_dvs   = wd_reg;
                div_steps = rrm_pkg::STEPS_FULL;
            end
            rrm_pkg::DIV_COUNT: begin
                div_num   = {wd_reg, {rrm_pkg::FRAC_W{1'b0}}};
                div_dvs   = TW'(period_eff);
                div_steps = rrm_pkg::STEPS_TIME;
            end
            rrm_pkg::DIV_ADV: begin
                div_rem0  = mul_hi;
                div_num   = {mul_lo, {rrm_pkg::FRAC_W{1'b0}}};
                div_dvs   = wd_reg;
                div_steps = rrm_pkg::STEPS_TIME;
            end
            default: begin
                div_steps = rrm_pkg::STEPS_FULL;
            end
        endcase
    end

    rrm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .rem_init  (div_rem0),
        .dividend  (div_num),
        .divisor   (div_dvs),
        .steps     (div_steps),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    rrm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .mcand   (sd_reg),
        .mplier  (adv),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod_hi (mul_hi),
        .prod_lo (mul_lo)
    );

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            last_sim_reg  <= '0;
            last_wall_reg <= '0;
            origin_reg    <= '0;
            period_reg    <= rrm_pkg::PERIOD_RESET;
        end else begin
            if (cfg_we) begin
                period_reg <= cfg_data;
            end
            if (cmd.mark_origin) begin
                started_reg   <= 1'b1;
                last_sim_reg  <= item_reg.sim_time;
                last_wall_reg <= '0;
                origin_reg    <= item_reg.wall_time;
            end else if (cmd.update) begin
                last_wall_reg <= last_wall_reg + adv_reg;
                last_sim_reg  <= last_sim_reg + div_quo[TW-1:0];
            end
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
        end
        if (cmd.eval_sub) begin
            sd_reg      <= sim_diff[TW-1:0];
            sim_lt_reg  <= sim_diff[TW];
            sim_eq_reg  <= (item_reg.sim_time == last_sim_reg);
            elapsed_reg <= item_reg.wall_time - origin_reg;
        end
        if (cmd.eval_wall) begin
            wd_reg <= elapsed_reg - last_wall_reg;
        end
        if (cmd.cap_rate) begin
            rate_reg <= (div_quo[rrm_pkg::QUO_W-1:rrm_pkg::RATE_W] != '0) ?
                        '1 : div_quo[rrm_pkg::RATE_W-1:0];
        end
        if (cmd.cap_count) begin
            count_reg <= (div_quo[TW-1:rrm_pkg::COUNT_W] != '0) ?
                         '1 : div_quo[rrm_pkg::COUNT_W-1:0];
            adv_reg   <= adv;
        end
        if (cmd.emit) begin
            out_reg.status <= cmd.result;
            if (cmd.result == rrm_pkg::RRM_COMPUTED) begin
                out_reg.whole_periods <= count_reg;
                out_reg.rate          <= rate_reg;
            end else begin
                out_reg.whole_periods <= '0;
                out_reg.rate          <= '0;
            end
        end
    end

    always_comb begin
        status.invalid    = item_reg.sim_time_invalid;
        status.started    = started_reg;
        status.sim_lt     = sim_lt_reg;
        status.sim_eq     = sim_eq_reg;
        status.short_wait = (wd_reg < TW'(period_eff));
        status.div_done   = div_done;
        status.mul_done   = mul_done;
        status.div_busy   = div_busy;
        status.mul_busy   = mul_busy;
    end

    assign out_item = out_reg;

endmodule
`default_nettype wire

>>> hdl/rrm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_ctrl
// Sequencer: classifies each item and steps the divider and multiplier.
// ----------------------------------------------------------------------------
module rrm_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire rrm_pkg::dp_status_t  status,
    output rrm_pkg::dp_cmd_t          cmd
);

    rrm_pkg::ctrl_state_t state_reg, state_next;
    rrm_pkg::status_t     result_reg, result_next;
    logic                 m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrm_pkg::ST_IDLE;
            result_reg  <= rrm_pkg::RRM_INCOMPLETE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            result_reg  <= result_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        result_next = result_reg;
        cmd         = '0;
        cmd.div_op  = rrm_pkg::DIV_RATE;
        cmd.result  = result_reg;
        s_ready     = 1'b0;
        case (state_reg)
            rrm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = rrm_pkg::ST_EVAL_SUB;
                end
            end
            rrm_pkg::ST_EVAL_SUB: begin
                cmd.eval_sub = 1'b1;
                state_next   = rrm_pkg::ST_EVAL_WALL;
            end
            rrm_pkg::ST_EVAL_WALL: begin
                cmd.eval_wall = 1'b1;
                state_next    = rrm_pkg::ST_DECIDE;
            end
            rrm_pkg::ST_DECIDE: begin
                state_next = rrm_pkg::ST_RESULT;
                if (status.invalid) begin
                    result_next = rrm_pkg::RRM_INCOMPLETE;
                end else if (!status.started || status.sim_lt) begin
                    cmd.mark_origin = 1'b1;
                    result_next     = rrm_pkg::RRM_INITIALIZED;
                end else if (status.sim_eq || status.short_wait) begin
                    result_next = rrm_pkg::RRM_INCOMPLETE;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = rrm_pkg::DIV_RATE;
                    state_next    = rrm_pkg::ST_RATE_DIV;
                end
            end
            rrm_pkg::ST_RATE_DIV: begin
                cmd.div_op = rrm_pkg::DIV_COUNT;
                if (status.div_done) begin
                    cmd.cap_rate  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = rrm_pkg::ST_COUNT_DIV;
                end
            end
            rrm_pkg::ST_COUNT_DIV: begin
                cmd.div_op = rrm_pkg::DIV_COUNT;
                if (status.div_done) begin
                    cmd.cap_count = 1'b1;
                    cmd.mul_start = 1'b1;
                    state_next    = rrm_pkg::ST_ADV_MUL;
                end
            end
            rrm_pkg::ST_ADV_MUL: begin
                cmd.div_op = rrm_pkg::DIV_ADV;
                if (status.mul_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = rrm_pkg::ST_ADV_DIV;
                end
            end
            rrm_pkg::ST_ADV_DIV: begin
                cmd.div_op = rrm_pkg::DIV_ADV;
                if (status.div_done) begin
                    cmd.update  = 1'b1;
                    result_next = rrm_pkg::RRM_COMPUTED;
                    state_next  = rrm_pkg::ST_RESULT;
                end
            end
            rrm_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = rrm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

>>> sim/tb_realtime_rate_meter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_realtime_rate_meter_core
// Self-checking testbench for the realtime rate meter core. Timestamp items
// go in over a valid/ready channel with bursty, gapped timing. A built-in
// rate predictor tracks the origin, the period marks and the period length,
// and works out the status, period count and Q16.16 rate for every item taken.
// Results come back under random stalls and are compared field by field.
// Directed items cover origins, repeats, short waits, saturation and wall
// wrap. Random phases then sweep the period length across its extremes.
// ----------------------------------------------------------------------------
module tb_realtime_rate_meter_core;

    localparam int TW             = rrm_pkg::TIME_W;
    localparam int PW             = rrm_pkg::PERIOD_W;
    localparam int FW             = rrm_pkg::FRAC_W;
    localparam int RW             = rrm_pkg::RATE_W;
    localparam int CW             = rrm_pkg::COUNT_W;
    localparam int CLK_HALF       = 2;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 250;
    localparam int PHASE_ITEMS    = 88;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    rrm_pkg::in_item_t   s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    rrm_pkg::out_item_t  m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PW-1:0]       cfg_data  = '0;

    // rate predictor state
    logic                mark_started;
    logic [TW-1:0]       sim_mark;
    logic [TW-1:0]       wall_mark;
    logic [TW-1:0]       wall_base;
    logic [PW-1:0]       period_reg;

    rrm_pkg::out_item_t  expected_results[$];
    rrm_pkg::out_item_t  expected_head;
    int unsigned         error_count  = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         ready_hold   = 0;
    int unsigned         ready_pick;
    int unsigned         burst_left   = 0;

    // stimulus cursors for well-formed sequences
    logic [TW-1:0]       cur_sim  = '0;
    logic [TW-1:0]       cur_wall = '0;

    realtime_rate_meter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic logic [TW-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TW-1:0];
    endfunction

    function automatic rrm_pkg::in_item_t make_item(input logic [TW-1:0] sim,
                                                    input logic inv,
                                                    input logic [TW-1:0] wall);
        rrm_pkg::in_item_t it;
        it.sim_time         = sim;
        it.sim_time_invalid = inv;
        it.wall_time        = wall;
        return it;
    endfunction

    function automatic rrm_pkg::out_item_t predict_rate_result(input rrm_pkg::in_item_t it);
        rrm_pkg::out_item_t r;
        logic [TW-1:0]      period;
        logic [TW-1:0]      sim_gap;
        logic [TW-1:0]      elapsed;
        logic [TW-1:0]      wall_gap;
        logic [TW-1:0]      count;
        logic [TW-1:0]      advance;
        logic [127:0]       scaled;
        r = '0;
        r.status = rrm_pkg::RRM_INCOMPLETE;
        period = (period_reg == '0) ? TW'(1) : TW'(period_reg);
        if (it.sim_time_invalid) begin
            return r;
        end
        if (!mark_started || it.sim_time < sim_mark) begin
            sim_mark     = it.sim_time;
            wall_mark    = '0;
            wall_base    = it.wall_time;
            mark_started = 1'b1;
            r.status     = rrm_pkg::RRM_INITIALIZED;
            return r;
        end
        if (it.sim_time == sim_mark) begin
            return r;
        end
        sim_gap  = it.sim_time - sim_mark;
        elapsed  = it.wall_time - wall_base;
        wall_gap = elapsed - wall_mark;
        if (wall_gap < period) begin
            return r;
        end
        if (sim_gap / wall_gap >= TW'(65536)) begin
            r.rate = '1;
        end else begin
            scaled = ({80'd0, sim_gap} << FW) / {80'd0, wall_gap};
            r.rate = scaled[RW-1:0];
        end
        count   = wall_gap / period;
        advance = count * period;
        scaled  = ({80'd0, sim_gap} * {80'd0, advance}) / {80'd0, wall_gap};
        wall_mark = wall_mark + advance;
        sim_mark  = sim_mark + scaled[TW-1:0];
        r.status        = rrm_pkg::RRM_COMPUTED;
        r.whole_periods = (count > TW'(65535)) ? 16'hFFFF : count[CW-1:0];
        return r;
    endfunction

    // prediction on accepted items and checks on accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            mark_started <= 1'b0;
            sim_mark     <= '0;
            wall_mark    <= '0;
            wall_base    <= '0;
            period_reg   <= rrm_pkg::PERIOD_RESET;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: status %0d count %0d rate %h",
                             $time, m_data.status, m_data.whole_periods, m_data.rate);
                end else begin
                    expected_head = expected_results.pop_front();
                    if (m_data.status != expected_head.status) begin
                        error_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, expected_head.status, m_data.status);
                    end
                    if (m_data.whole_periods != expected_head.whole_periods) begin
                        error_count++;
                        $display("%0t: whole_periods mismatch: expected %0d, actual %0d",
                                 $time, expected_head.whole_periods, m_data.whole_periods);
                    end
                    if (m_data.rate != expected_head.rate) begin
                        error_count++;
                        $display("%0t: rate mismatch: expected %h, actual %h",
                                 $time, expected_head.rate, m_data.rate);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                period_reg = cfg_data;
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_rate_result(s_data));
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_pick = $urandom_range(0, 15);
            if (ready_pick < 9) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 40);
            end else if (ready_pick < 12) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else if (ready_pick < 15) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(4, 30);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(60, 300);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no handshake for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_item(input rrm_pkg::in_item_t it);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 250);
            end else begin
                gap = $urandom_range(1, 6);
            end
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic settle_results();
        s_valid <= 1'b0;
        burst_left = $urandom_range(0, 24);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_period(input logic [PW-1:0] value);
        settle_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_first_marks();
        send_item(make_item(rand_time(), 1'b1, rand_time()));
        send_item(make_item(48'd1000, 1'b0, 48'd5000));
        send_item(make_item(48'd1000, 1'b0, 48'd9000000));
        send_item(make_item(48'd2000, 1'b0, 48'd5000 + 48'd999999));
        send_item(make_item(48'd3000, 1'b0, 48'd5000 + 48'd1000000));
        send_item(make_item(48'd503000, 1'b0, 48'd3505000));
        send_item(make_item(48'd10, 1'b0, 48'd0));
        send_item(make_item('1, 1'b1, '1));
        settle_results();
    endtask

    task automatic test_period_extremes();
        write_period(32'd1);
        send_item(make_item(48'd0, 1'b0, 48'd0));
        send_item(make_item(48'd1, 1'b0, 48'd1));
        send_item(make_item('1, 1'b0, 48'd2));
        send_item(make_item('1, 1'b0, 48'd3));
        send_item(make_item(48'd5, 1'b0, 48'd7));
        send_item(make_item(48'd6, 1'b0, 48'd200007));
        write_period(32'd0);
        send_item(make_item(48'd7, 1'b0, 48'd200008));
        send_item(make_item(48'd8, 1'b0, 48'd200008));
        settle_results();
    endtask

    task automatic test_wall_wrap();
        write_period(32'hFFFF_FFFF);
        send_item(make_item(48'd1, 1'b0, '1 - 48'd9));
        send_item(make_item(48'd2, 1'b0, 48'h1_0000_0000));
        send_item(make_item(48'd3, 1'b0, 48'd100));
        send_item(make_item(48'd4, 1'b0, 48'd101));
        settle_results();
    endtask

    task automatic test_random_traffic();
        logic [PW-1:0] phase_period [6];
        logic [TW-1:0] p;
        logic [63:0]   sim_step;
        logic [63:0]   wall_step;
        int unsigned   kind;
        phase_period[0] = PW'($urandom_range(1, 16));
        phase_period[1] = PW'($urandom_range(17, 5000));
        phase_period[2] = rrm_pkg::PERIOD_RESET;
        phase_period[3] = $urandom;
        phase_period[4] = 32'hFFFF_FFFF;
        phase_period[5] = '0;
        for (int ph = 0; ph < 6; ph++) begin
            write_period(phase_period[ph]);
            p = (phase_period[ph] == '0) ? TW'(1) : TW'(phase_period[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) begin
                    settle_results();
                end
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    sim_step = ({$urandom, $urandom} >> $urandom_range(16, 63)) + 64'd1;
                    case ($urandom_range(0, 9))
                        0, 1, 2: wall_step = {$urandom, $urandom} % 64'(p);
                        8:       wall_step = {$urandom, $urandom} >> $urandom_range(16, 40);
                        9:       wall_step = '0;
                        default: wall_step = 64'(p) * $urandom_range(1, 3)
                                             + {$urandom, $urandom} % 64'(p);
                    endcase
                    cur_sim  = cur_sim + sim_step[TW-1:0];
                    cur_wall = cur_wall + wall_step[TW-1:0];
                    send_item(make_item(cur_sim, 1'b0, cur_wall));
                end else if (kind < 78) begin
                    send_item(make_item(rand_time(), 1'b1, rand_time()));
                end else if (kind < 86) begin
                    cur_sim  = (sim_mark == '0) ? '0 : rand_time() % sim_mark;
                    cur_wall = rand_time();
                    send_item(make_item(cur_sim, 1'b0, cur_wall));
                end else if (kind < 93) begin
                    cur_wall = cur_wall + TW'($urandom_range(0, 3)) * p;
                    send_item(make_item(sim_mark, 1'b0, cur_wall));
                end else begin
                    cur_sim  = rand_time();
                    cur_wall = rand_time();
                    send_item(make_item(cur_sim, 1'b0, cur_wall));
                end
            end
        end
        settle_results();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_marks();
        test_period_extremes();
        test_wall_wrap();
        test_random_traffic();
        settle_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
